// ----- sv/tpp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and reset values for the truecolor pixel packer.
// No dependencies.
package tpp_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned WORD_W     = 32;

	typedef enum logic [2:0] {
		REG_RED_BITS      = 3'd0,
		REG_GREEN_BITS    = 3'd1,
		REG_BLUE_BITS     = 3'd2,
		REG_PIXEL_SIZE    = 3'd3,
		REG_MSB_FIRST     = 3'd4,
		REG_SOURCE_FORMAT = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		SRC_COLOR  = 2'd0,
		SRC_GREY8  = 2'd1,
		SRC_GREY16 = 2'd2
	} src_fmt_t;

	typedef enum logic [1:0] {
		PIX_8  = 2'd0,
		PIX_16 = 2'd1,
		PIX_24 = 2'd2,
		PIX_32 = 2'd3
	} pix_size_t;

	typedef struct packed {
		logic [31:0] red_bits;
		logic [31:0] green_bits;
		logic [31:0] blue_bits;
		logic [1:0]  pixel_size;
		logic        msb_first;
		logic [1:0]  source_format;
	} cfg_t;

	localparam logic [31:0] RED_BITS_RST   = 32'h00FF_0000;
	localparam logic [31:0] GREEN_BITS_RST = 32'h0000_FF00;
	localparam logic [31:0] BLUE_BITS_RST  = 32'h0000_00FF;

	// Highest set bit; zero for an empty mask (the mask clears the result anyway).
	function automatic logic [4:0] top_bit(input logic [31:0] v);
		logic [4:0] pos;
		pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				pos = 5'(i);
			end
		end
		return pos;
	endfunction

	// Put bit 7 of an 8-bit channel on bit h of the word.
	function automatic logic [31:0] place(input logic [7:0] val, input logic [4:0] h,
		input logic [31:0] mask);
		logic [31:0] sh;
		sh = {val, 24'h0} >> (5'd31 - h);
		return sh & mask;
	endfunction

endpackage

// ----- sv/tpp_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts source pixels, picks the channel values and packs the word.
// Depends on tpp_pkg.
module tpp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tpp_pkg::cfg_t     cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // first_byte, second_byte, third_byte, wide_sample
	output logic              push,
	output logic [31:0]       push_word,
	input  logic              full
);

	logic [7:0] r_s1, g_s1, b_s1;
	logic       v_s1;
	logic [4:0] red_top_q, green_top_q, blue_top_q;
	logic [7:0] r_sel, g_sel, b_sel;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_top_q   <= 5'd23;
			green_top_q <= 5'd15;
			blue_top_q  <= 5'd7;
		end else begin
			red_top_q   <= tpp_pkg::top_bit(cfg.red_bits);
			green_top_q <= tpp_pkg::top_bit(cfg.green_bits);
			blue_top_q  <= tpp_pkg::top_bit(cfg.blue_bits);
		end
	end

	always_comb begin
		unique case (cfg.source_format)
			tpp_pkg::SRC_GREY8: begin
				r_sel = s_tdata[7:0];
				g_sel = s_tdata[7:0];
				b_sel = s_tdata[7:0];
			end
			tpp_pkg::SRC_GREY16: begin
				r_sel = s_tdata[39:32];
				g_sel = s_tdata[39:32];
				b_sel = s_tdata[39:32];
			end
			default: begin
				r_sel = s_tdata[7:0];
				g_sel = s_tdata[15:8];
				b_sel = s_tdata[23:16];
			end
		endcase
	end

	assign push     = v_s1 && !full;
	assign s_tready = !v_s1 || !full;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1 <= r_sel;
			g_s1 <= g_sel;
			b_s1 <= b_sel;
		end
	end

	assign push_word = tpp_pkg::place(r_s1, red_top_q, cfg.red_bits)
		| tpp_pkg::place(g_s1, green_top_q, cfg.green_bits)
		| tpp_pkg::place(b_s1, blue_top_q, cfg.blue_bits);

endmodule

// ----- sv/tpp_fifo.sv -----
`timescale 1ns / 1ps
// Short word queue between the packing front end and the byte serializer.
// Depends on nothing but its parameters.
module tpp_fifo #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

endmodule

// ----- sv/tpp_back.sv -----
`timescale 1ns / 1ps
// Back end: serializes each queued pixel word into 1..4 bytes in configured order.
// Depends on tpp_pkg.
module tpp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tpp_pkg::cfg_t cfg,
	input  logic [31:0]   head,
	input  logic          not_empty,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // out_byte
	output logic          m_tlast    // pixel_done
);

	logic [1:0] k_q;
	logic [1:0] pos;
	logic       out_free, emit, last;
	logic [7:0] byte_sel;

	assign out_free = !m_tvalid || m_tready;
	assign emit     = out_free && not_empty;
	assign last     = (k_q == cfg.pixel_size);
	assign pop      = emit && last;

	always_comb begin
		if (cfg.msb_first && cfg.pixel_size != tpp_pkg::PIX_8) begin
			pos = cfg.pixel_size - k_q;
		end else begin
			pos = k_q;
		end
		unique case (pos)
			2'd0: byte_sel = head[7:0];
			2'd1: byte_sel = head[15:8];
			2'd2: byte_sel = head[23:16];
			default: byte_sel = head[31:24];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (emit) begin
				k_q <= last ? 2'd0 : k_q + 2'd1;
			end
			if (out_free) begin
				m_tvalid <= not_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= byte_sel;
			m_tlast <= last;
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> k_q == 2'd0)
		else $error("byte counter not at zero with empty queue");
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid && m_tlast)
		else $error("word retired without a final byte");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> k_q <= cfg.pixel_size)
		else $error("byte counter past pixel size");

endmodule

// ----- sv/truecolor_pixel_packer_core.sv -----
`timescale 1ns / 1ps
// Top level of the truecolor pixel packer: configuration registers and the
// front end, queue and byte serializer. Depends on tpp_pkg and all tpp_ modules.
//
// Each accepted pixel becomes pixel_size+1 output bytes, one byte per cycle while
// m_tready allows, so the byte serializer sets the sustained pixel rate. A new
// pixel is accepted every cycle while the queue has room; the first byte of a
// pixel passes the front-end register and the queue before it is offered. A mask
// write reaches cfg_q first and the front end's top-bit registers after it.
module truecolor_pixel_packer_core #(
	parameter int unsigned FIFO_DEPTH = tpp_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // first_byte, second_byte, third_byte, wide_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast    // pixel_done
);

	tpp_pkg::cfg_t cfg_q;
	logic          push, full, pop, not_empty;
	logic [31:0]   push_word, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_bits      <= tpp_pkg::RED_BITS_RST;
			cfg_q.green_bits    <= tpp_pkg::GREEN_BITS_RST;
			cfg_q.blue_bits     <= tpp_pkg::BLUE_BITS_RST;
			cfg_q.pixel_size    <= tpp_pkg::PIX_32;
			cfg_q.msb_first     <= 1'b0;
			cfg_q.source_format <= tpp_pkg::SRC_COLOR;
		end else if (cfg_we) begin
			case (cfg_index)
				tpp_pkg::REG_RED_BITS:      cfg_q.red_bits      <= cfg_wdata;
				tpp_pkg::REG_GREEN_BITS:    cfg_q.green_bits    <= cfg_wdata;
				tpp_pkg::REG_BLUE_BITS:     cfg_q.blue_bits     <= cfg_wdata;
				tpp_pkg::REG_PIXEL_SIZE:    cfg_q.pixel_size    <= cfg_wdata[1:0];
				tpp_pkg::REG_MSB_FIRST:     cfg_q.msb_first     <= cfg_wdata[0];
				tpp_pkg::REG_SOURCE_FORMAT: cfg_q.source_format <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	tpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	tpp_fifo #(
		.WIDTH (tpp_pkg::WORD_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_word),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	tpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
